FILE: sv/frrbs_pkg.sv
`default_nettype none
package frrbs_pkg;

  localparam int MAX_PROCS_DEF  = 16;
  localparam int BURST_BITS_DEF = 16;

  localparam int WAIT_W       = 20;
  localparam int PID_W        = 4;
  localparam int QUANT_W      = 16;
  localparam int BURST_IN_W   = 16;
  localparam int ACT_W        = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int RESULT_LIMIT = 16;

  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RUN   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'd1;

  localparam logic [1:0] PM_SCAN = 2'd0;
  localparam logic [1:0] PM_FCFS = 2'd1;
  localparam logic [1:0] PM_RR   = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic [BURST_IN_W-1:0] burst_length;
  } in_req_t;

  typedef struct packed {
    logic [PID_W-1:0]  process_id;
    logic [WAIT_W-1:0] wait_time;
    logic [WAIT_W-1:0] total_elapsed;
    logic              last_report;
    logic              table_empty;
  } out_res_t;

  typedef struct packed {
    logic       start;
    logic       clr_time;
    logic [1:0] mode;
  } pass_cmd_t;

  typedef struct packed {
    logic done;
    logic any_active;
  } pass_sts_t;

endpackage
`default_nettype wire

FILE: sv/frrbs_div.sv
`default_nettype none
module frrbs_div #(
  parameter int N = 16,
  parameter int D = 16,
  localparam int CW = $clog2(N + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [D-1:0]  rem_r;
  logic [N-1:0]  num_r;
  logic [D:0]    trial;
  logic [D:0]    diff;
  logic          fit;

  assign trial = {rem_r, num_r[N-1]};
  assign fit   = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      cnt_r <= CW'(N);
    end else if (busy_r) begin
      num_r <= {num_r[N-2:0], fit};
      rem_r <= fit ? diff[D-1:0] : trial[D-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule
`default_nettype wire

FILE: sv/frrbs_table.sv
`default_nettype none
module frrbs_table #(
  parameter int MAX_PROCS  = 16,
  parameter int BURST_BITS = 16,
  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  localparam int CNT_W = $clog2(MAX_PROCS + 1),
  localparam int T_W   = BURST_BITS + CNT_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             ld_en,
  input  logic [IDX_W-1:0]                 ld_addr,
  input  logic [BURST_BITS-1:0]            ld_burst,
  input  logic [IDX_W-1:0]                 rd_addr,
  output logic [frrbs_pkg::WAIT_W-1:0]     rd_wait,
  input  frrbs_pkg::pass_cmd_t             pass_cmd,
  input  logic [CNT_W-1:0]                 pass_len,
  input  logic [BURST_BITS-1:0]            pass_per,
  input  logic [frrbs_pkg::QUANT_W-1:0]    pass_quantum,
  input  logic [T_W-1:0]                   pass_tadd,
  output frrbs_pkg::pass_sts_t             pass_sts,
  output logic [BURST_BITS-1:0]            min_rem,
  output logic [CNT_W-1:0]                 active_cnt,
  output logic [T_W-1:0]                   elapsed
);
  import frrbs_pkg::*;

  localparam int WORD_W = 2 * BURST_BITS + WAIT_W;
  localparam int CMP_W  = (BURST_BITS > QUANT_W) ? BURST_BITS : QUANT_W;
  localparam int EXT_W  = T_W + WAIT_W;

  logic [WORD_W-1:0] mem_r [MAX_PROCS];
  logic [WORD_W-1:0] q_r;

  logic                  run_r;
  logic [IDX_W-1:0]      idx_r;
  logic [1:0]            mode_r;
  logic [T_W-1:0]        time_r;
  logic [BURST_BITS-1:0] min_r;
  logic [CNT_W-1:0]      act_r;
  logic                  done_r;

  logic                  p0_v_r;
  logic                  p0_last_r;
  logic [IDX_W-1:0]      p0_idx_r;

  logic                  s1_v_r;
  logic                  s1_last_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic                  s1_act_r;
  logic [BURST_BITS-1:0] s1_rem_r;
  logic [BURST_BITS-1:0] s1_orig_r;
  logic [WAIT_W-1:0]     s1_wait_r;

  logic                  s2_v_r;
  logic                  s2_last_r;
  logic [IDX_W-1:0]      s2_idx_r;
  logic                  s2_act_r;
  logic [BURST_BITS-1:0] s2_amt_r;
  logic [BURST_BITS-1:0] s2_rem_r;
  logic [BURST_BITS-1:0] s2_od_r;
  logic [BURST_BITS-1:0] s2_orig_r;
  logic [WAIT_W-1:0]     s2_wait_r;

  logic [IDX_W-1:0]      rd_sel;
  logic                  issue_last;
  logic [BURST_BITS-1:0] q_orig;
  logic [BURST_BITS-1:0] q_rem;
  logic [WAIT_W-1:0]     q_wait;
  logic [BURST_BITS-1:0] amt;
  logic [EXT_W-1:0]      wait_wide;
  logic [WAIT_W-1:0]     wait_sat;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [WORD_W-1:0]     wr_data;

  assign rd_sel     = run_r ? idx_r : rd_addr;
  assign issue_last = CNT_W'(idx_r) == pass_len - 1'b1;

  assign q_orig = q_r[WORD_W-1 -: BURST_BITS];
  assign q_rem  = q_r[WAIT_W +: BURST_BITS];
  assign q_wait = q_r[WAIT_W-1:0];

  always_comb begin
    case (mode_r)
      PM_FCFS: amt = s1_rem_r;
      PM_RR:   amt = (CMP_W'(s1_rem_r) < CMP_W'(pass_quantum)) ? s1_rem_r
                                                              : BURST_BITS'(pass_quantum);
      default: amt = '0;
    endcase
  end

  assign wait_wide = EXT_W'(time_r - T_W'(s2_od_r));
  assign wait_sat  = (wait_wide > EXT_W'(WAIT_MAX)) ? WAIT_MAX : wait_wide[WAIT_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s2_idx_r;
    wr_data = {s2_orig_r, s2_rem_r, (s2_rem_r == '0) ? wait_sat : s2_wait_r};
    if (ld_en) begin
      wr_en   = 1'b1;
      wr_addr = ld_addr;
      wr_data = {ld_burst, ld_burst, {WAIT_W{1'b0}}};
    end else if (s2_v_r && s2_act_r) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    q_r <= mem_r[rd_sel];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      p0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (pass_cmd.start) begin
        run_r <= 1'b1;
      end else if (run_r && issue_last) begin
        run_r <= 1'b0;
      end
      p0_v_r <= run_r;
      s1_v_r <= p0_v_r;
      s2_v_r <= s1_v_r;
      done_r <= s2_v_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pass_cmd.start) begin
      idx_r  <= '0;
      mode_r <= pass_cmd.mode;
      time_r <= pass_cmd.clr_time ? '0 : time_r + pass_tadd;
      min_r  <= '1;
      act_r  <= '0;
    end else begin
      if (run_r) begin
        idx_r <= idx_r + 1'b1;
      end
      if (s2_v_r && s2_act_r) begin
        time_r <= time_r + T_W'(s2_amt_r);
        if (s2_rem_r != '0) begin
          act_r <= act_r + 1'b1;
          if (s2_rem_r < min_r) begin
            min_r <= s2_rem_r;
          end
        end
      end
    end

    p0_last_r <= issue_last;
    p0_idx_r  <= idx_r;

    s1_last_r <= p0_last_r;
    s1_idx_r  <= p0_idx_r;
    s1_act_r  <= q_rem != '0;
    s1_rem_r  <= (mode_r == PM_RR) ? q_rem - pass_per : q_rem;
    s1_orig_r <= q_orig;
    s1_wait_r <= q_wait;

    s2_last_r <= s1_last_r;
    s2_idx_r  <= s1_idx_r;
    s2_act_r  <= s1_act_r;
    s2_amt_r  <= amt;
    s2_rem_r  <= s1_rem_r - amt;
    s2_od_r   <= s1_orig_r - amt;
    s2_orig_r <= s1_orig_r;
    s2_wait_r <= s1_wait_r;
  end

  assign rd_wait             = q_wait;
  assign pass_sts.done       = done_r;
  assign pass_sts.any_active = act_r != '0;
  assign min_rem             = min_r;
  assign active_cnt          = act_r;
  assign elapsed             = time_r;

endmodule
`default_nettype wire

FILE: sv/fcfs_round_robin_burst_scheduler.sv
`default_nettype none
// Clear and load requests leave busy low; an empty run gives its result in the cycle after
// the request. A first-come-first-serve run makes one table pass before its results stream out
// one per cycle; a round-robin run takes up to n + 1 table passes, computing the quotient
// and products between passes, and its results then stream out the same way.
// The single-port-per-direction table memory sets the one-entry-per-cycle pass rate.
// Reset (synchronous, active low) empties the table and sets round-robin with a quantum of one.
module fcfs_round_robin_burst_scheduler #(
  parameter int MAX_PROCS  = frrbs_pkg::MAX_PROCS_DEF,
  parameter int BURST_BITS = frrbs_pkg::BURST_BITS_DEF,
  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  localparam int CNT_W = $clog2(MAX_PROCS + 1),
  localparam int T_W   = BURST_BITS + CNT_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  frrbs_pkg::in_req_t              in_req,
  output logic                            out_valid,
  output frrbs_pkg::out_res_t             out_res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [frrbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frrbs_pkg::QUANT_W-1:0]   cfg_data
);
  import frrbs_pkg::*;

  localparam int EXT_W  = T_W + WAIT_W;
  localparam int PROD_W = BURST_BITS + QUANT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PASS   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_TADD   = 3'd4;
  localparam logic [2:0] S_GO     = 3'd5;
  localparam logic [2:0] S_REPORT = 3'd6;
  localparam logic [2:0] S_TAIL   = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  policy_r;
  logic [QUANT_W-1:0]    quantum_r;
  logic [BURST_BITS-1:0] per_r, per_nxt;
  logic [T_W-1:0]        tadd_r, tadd_nxt;
  logic [WAIT_W-1:0]     elapsed_r, elapsed_nxt;
  logic [IDX_W-1:0]      rep_idx_r, rep_idx_nxt;
  logic                  rep_v_r;
  logic                  rep_last_r;
  logic [PID_W-1:0]      rep_pid_r;
  logic                  out_valid_r;
  out_res_t              out_res_r;

  logic                  accept;
  logic                  ld_en;
  logic                  empty_hit;
  logic                  rep_issue;
  logic                  rep_last;
  logic                  div_start;
  logic                  div_done;
  logic [BURST_BITS-1:0] div_q;
  pass_cmd_t             cmd;
  pass_sts_t             sts;
  logic [BURST_BITS-1:0] min_rem;
  logic [CNT_W-1:0]      active_cnt;
  logic [T_W-1:0]        elapsed;
  logic [WAIT_W-1:0]     rd_wait;
  logic [EXT_W-1:0]      elapsed_wide;
  logic [WAIT_W-1:0]     elapsed_sat;
  logic [CNT_W-1:0]      shown;
  logic [PROD_W-1:0]     per_prod;
  logic [T_W-1:0]        tadd_prod;

  assign accept = start && !busy;

  assign elapsed_wide = EXT_W'(elapsed);
  assign elapsed_sat  = (elapsed_wide > EXT_W'(WAIT_MAX)) ? WAIT_MAX
                                                          : elapsed_wide[WAIT_W-1:0];
  assign shown = (32'(cnt_r) > RESULT_LIMIT) ? CNT_W'(RESULT_LIMIT) : cnt_r;

  assign per_prod  = PROD_W'(div_q) * PROD_W'(quantum_r);
  assign tadd_prod = T_W'(per_r) * T_W'(active_cnt);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    per_nxt     = per_r;
    tadd_nxt    = tadd_r;
    elapsed_nxt = elapsed_r;
    rep_idx_nxt = rep_idx_r;
    cmd         = '0;
    div_start   = 1'b0;
    ld_en       = 1'b0;
    empty_hit   = 1'b0;
    rep_issue   = 1'b0;
    rep_last    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req.action)
            ACT_CLEAR: cnt_nxt = '0;
            ACT_LOAD: begin
              if (cnt_r < CNT_W'(MAX_PROCS)) begin
                ld_en   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            ACT_RUN: begin
              if (cnt_r == '0) begin
                empty_hit = 1'b1;
              end else if (!policy_r) begin
                cmd.start    = 1'b1;
                cmd.clr_time = 1'b1;
                cmd.mode     = PM_FCFS;
                per_nxt      = '0;
                state_nxt    = S_PASS;
              end else if (quantum_r == '0) begin
                elapsed_nxt = '0;
                rep_idx_nxt = '0;
                state_nxt   = S_REPORT;
              end else begin
                cmd.start    = 1'b1;
                cmd.clr_time = 1'b1;
                cmd.mode     = PM_SCAN;
                per_nxt      = '0;
                state_nxt    = S_PASS;
              end
            end
            default: ;
          endcase
        end
      end
      S_PASS: begin
        if (sts.done) begin
          if (!policy_r || !sts.any_active) begin
            elapsed_nxt = elapsed_sat;
            rep_idx_nxt = '0;
            state_nxt   = S_REPORT;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        per_nxt   = per_prod[BURST_BITS-1:0];
        state_nxt = S_TADD;
      end
      S_TADD: begin
        tadd_nxt  = tadd_prod;
        state_nxt = S_GO;
      end
      S_GO: begin
        cmd.start = 1'b1;
        cmd.mode  = PM_RR;
        state_nxt = S_PASS;
      end
      S_REPORT: begin
        rep_issue   = 1'b1;
        rep_last    = CNT_W'(rep_idx_r) == shown - 1'b1;
        rep_idx_nxt = rep_idx_r + 1'b1;
        if (rep_last) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      policy_r    <= 1'b1;
      quantum_r   <= QUANT_W'(1);
      rep_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rep_v_r     <= rep_issue;
      out_valid_r <= rep_v_r || empty_hit;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_POLICY:  policy_r  <= cfg_data[0];
          CFG_QUANTUM: quantum_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    per_r      <= per_nxt;
    tadd_r     <= tadd_nxt;
    elapsed_r  <= elapsed_nxt;
    rep_idx_r  <= rep_idx_nxt;
    rep_last_r <= rep_last;
    rep_pid_r  <= PID_W'(rep_idx_r);
    if (empty_hit) begin
      out_res_r.process_id    <= '0;
      out_res_r.wait_time     <= '0;
      out_res_r.total_elapsed <= '0;
      out_res_r.last_report   <= 1'b1;
      out_res_r.table_empty   <= 1'b1;
    end else begin
      out_res_r.process_id    <= rep_pid_r;
      out_res_r.wait_time     <= rd_wait;
      out_res_r.total_elapsed <= elapsed_r;
      out_res_r.last_report   <= rep_last_r;
      out_res_r.table_empty   <= 1'b0;
    end
  end

  frrbs_table #(
    .MAX_PROCS  (MAX_PROCS),
    .BURST_BITS (BURST_BITS)
  ) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .ld_en        (ld_en),
    .ld_addr      (IDX_W'(cnt_r)),
    .ld_burst     (BURST_BITS'(in_req.burst_length)),
    .rd_addr      (rep_idx_r),
    .rd_wait      (rd_wait),
    .pass_cmd     (cmd),
    .pass_len     (cnt_r),
    .pass_per     (per_r),
    .pass_quantum (quantum_r),
    .pass_tadd    (tadd_r),
    .pass_sts     (sts),
    .min_rem      (min_rem),
    .active_cnt   (active_cnt),
    .elapsed      (elapsed)
  );

  frrbs_div #(
    .N (BURST_BITS),
    .D (QUANT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (min_rem - 1'b1),
    .divisor  (quantum_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign busy      = state_r != S_IDLE;
  assign cfg_ready = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

FILE: sim/testbench.sv
module testbench;
  import frrbs_pkg::*;

  localparam int  TABLE_SIZE  = MAX_PROCS_DEF;
  localparam int  CYCLE_LIMIT = 2_000_000;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  in_req_t         in_req = '0;
  logic            out_valid;
  out_res_t        out_res;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [QUANT_W-1:0]   cfg_data = '0;

  in_req_t         pending_requests[$];
  out_res_t        expected_reports[$];
  int              requests_issued = 0;
  int              requests_accepted = 0;
  int              sender_idle = 0;
  int              error_count = 0;
  int              cycle_count = 0;

  longint unsigned proc_burst[TABLE_SIZE];
  longint unsigned burst_wait[TABLE_SIZE];
  int              loaded_procs = 0;
  bit              policy_rr = 1'b1;
  logic [QUANT_W-1:0] quantum = 16'd1;

  fcfs_round_robin_burst_scheduler DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned clip20(input longint unsigned v);
    return (v > WAIT_MAX) ? WAIT_MAX : v;
  endfunction

  task automatic schedule_request(input in_req_t r);
    longint unsigned elapsed, q, k, rem, per, amt;
    int n, shown, active;
    out_res_t res;
    case (r.action)
      ACT_CLEAR: loaded_procs = 0;
      ACT_LOAD: begin
        if (loaded_procs < TABLE_SIZE) begin
          proc_burst[loaded_procs] = 64'(r.burst_length);
          burst_wait[loaded_procs] = 0;
          loaded_procs++;
        end
      end
      ACT_RUN: begin
        n = loaded_procs;
        if (n == 0) begin
          res = '0;
          res.last_report = 1'b1;
          res.table_empty = 1'b1;
          expected_reports.push_back(res);
        end else begin
          elapsed = 0;
          if (!policy_rr) begin
            for (int i = 0; i < n; i++) begin
              if (proc_burst[i] != 0) begin
                burst_wait[i] = clip20(elapsed);
                elapsed += proc_burst[i];
                proc_burst[i] = 0;
              end
            end
          end else if (quantum != 0) begin
            q = 64'(quantum);
            active = 1;
            while (active != 0) begin
              active = 0;
              k = 0;
              for (int i = 0; i < n; i++) begin
                if (proc_burst[i] != 0) begin
                  rem = (proc_burst[i] - 1) / q;
                  if (active == 0 || rem < k) k = rem;
                  active++;
                end
              end
              if (active != 0) begin
                // Whole rounds in which nobody finishes are taken in one step.
                per = k * q;
                for (int i = 0; i < n; i++) begin
                  if (proc_burst[i] != 0) begin
                    proc_burst[i] -= per;
                    burst_wait[i] = clip20(burst_wait[i] + per * longint'(active - 1));
                  end
                end
                elapsed += per * longint'(active);
                for (int i = 0; i < n; i++) begin
                  if (proc_burst[i] != 0) begin
                    amt = (proc_burst[i] < q) ? proc_burst[i] : q;
                    proc_burst[i] -= amt;
                    for (int j = 0; j < n; j++) begin
                      if (j != i && proc_burst[j] != 0) begin
                        burst_wait[j] = clip20(burst_wait[j] + amt);
                      end
                    end
                    elapsed += amt;
                  end
                end
              end
            end
          end
          elapsed = clip20(elapsed);
          shown = (n < RESULT_LIMIT) ? n : RESULT_LIMIT;
          for (int i = 0; i < shown; i++) begin
            res.process_id    = PID_W'(i);
            res.wait_time     = WAIT_W'(clip20(burst_wait[i]));
            res.total_elapsed = WAIT_W'(elapsed);
            res.last_report   = (i == shown - 1);
            res.table_empty   = 1'b0;
            expected_reports.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        schedule_request(in_req);
        requests_accepted++;
      end
      if (!start || !busy) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle) begin
          start  <= 1'b1;
          in_req <= pending_requests.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [WAIT_W-1:0] want,
                                      input logic [WAIT_W-1:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_valid) begin
      if (expected_reports.size() == 0) begin
        $error("report with no request outstanding: pid %0d", out_res.process_id);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("process_id", WAIT_W'(want.process_id), WAIT_W'(out_res.process_id));
        check_field("wait_time", want.wait_time, out_res.wait_time);
        check_field("total_elapsed", want.total_elapsed, out_res.total_elapsed);
        check_field("last_report", WAIT_W'(want.last_report), WAIT_W'(out_res.last_report));
        check_field("table_empty", WAIT_W'(want.table_empty), WAIT_W'(out_res.table_empty));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic add_request(input logic [ACT_W-1:0] action, input logic [BURST_IN_W-1:0] burst);
    in_req_t r;
    r.action = action;
    r.burst_length = burst;
    pending_requests.push_back(r);
    requests_issued++;
  endtask

  task automatic drain();
    while (requests_accepted != requests_issued || expected_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [QUANT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_POLICY) begin
      policy_rr = data[0];
    end else begin
      quantum = data;
    end
  endtask

  task automatic set_schedule(input bit rr, input logic [QUANT_W-1:0] q);
    write_register(CFG_POLICY, {(QUANT_W-1)'($urandom_range(32767)), rr});
    write_register(CFG_QUANTUM, q);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [BURST_IN_W-1:0] pick_burst();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return BURST_IN_W'($urandom);
      default: return BURST_IN_W'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic random_phase(input bit rr, input logic [QUANT_W-1:0] q, input int idle,
                              input int target);
    int counted, loads;
    counted = 0;
    drain();
    set_schedule(rr, q);
    sender_idle = idle;
    while (counted < target) begin
      if ($urandom_range(9) < 8) begin
        add_request(ACT_CLEAR, BURST_IN_W'($urandom));
        counted++;
      end
      case ($urandom_range(9))
        0:       loads = 0;
        1:       loads = $urandom_range(15, 17);
        default: loads = $urandom_range(1, 6);
      endcase
      for (int i = 0; i < loads; i++) begin
        add_request(ACT_LOAD, pick_burst());
        counted++;
        if ($urandom_range(19) == 0) add_request(ACT_UNUSED, BURST_IN_W'($urandom));
      end
      add_request(ACT_RUN, BURST_IN_W'($urandom));
      counted++;
      if ($urandom_range(4) == 0) begin
        add_request(ACT_RUN, BURST_IN_W'($urandom));
        counted++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_request(ACT_RUN, 16'h0000);
    add_request(ACT_UNUSED, 16'hFFFF);
    add_request(ACT_LOAD, 16'h0000);
    add_request(ACT_LOAD, 16'hFFFF);
    add_request(ACT_RUN, 16'hFFFF);
    add_request(ACT_RUN, 16'h0000);
    add_request(ACT_CLEAR, 16'hFFFF);
    drain();
    set_schedule(1'b0, 16'hFFFF);
    for (int i = 0; i <= TABLE_SIZE; i++) add_request(ACT_LOAD, 16'hFFFF);
    add_request(ACT_RUN, 16'h0000);
    drain();
    set_schedule(1'b1, 16'h0000);
    add_request(ACT_CLEAR, 16'h0000);
    add_request(ACT_LOAD, 16'd5);
    add_request(ACT_LOAD, 16'hFFFF);
    add_request(ACT_RUN, 16'h0000);

    random_phase(1'b1, 16'd1, 0, 43);
    random_phase(1'b0, QUANT_W'($urandom), 57, 43);
    random_phase(1'b1, 16'hFFFF, 34, 43);
    random_phase(1'b1, QUANT_W'($urandom_range(2, 8)), 0, 43);
    random_phase(1'b1, QUANT_W'($urandom_range(9, 300)), 57, 43);
    random_phase(1'b1, 16'h0000, 34, 30);
    random_phase(1'b0, 16'd1, 0, 43);
    random_phase(1'b1, QUANT_W'($urandom_range(1, 65535)), 34, 20);
    drain();
    repeat (50) @(posedge clk);

    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/frrbs_pkg.sv
sv/frrbs_div.sv
sv/frrbs_table.sv
sv/fcfs_round_robin_burst_scheduler.sv
sim/testbench.sv
